@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------
// Assertion macros
// Short forms for clocked checks used in the cache RTL.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, off while rst is high.
`define LKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clk edge, reset included.
`define LKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lkc_pkg.sv @@
// ----------------------------------------------------------------------
// lkc_pkg
// Shared types, constants and helpers for the LRU key cache.
// ----------------------------------------------------------------------
`default_nettype none
package lkc_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int STAMP_W       = 48;  // touch order stamp
  localparam int ACT_W         = 9;   // holds any capacity up to 256

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PREFIX = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Keeps the first n bytes (top first).
  function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[KEY_W-1-8*b -: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ design/lkc_mem.sv @@
// ----------------------------------------------------------------------
// lkc_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------
`default_nettype none
module lkc_mem
  import lkc_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEF,
  parameter int WIDTH = KEY_W + LEN_W + STAMP_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/lru_key_cache_with_prefix_touch.sv @@
// Flow: an item is accepted, then the slot memory is swept over the filled
// slots and the finish state writes back; done strobes the cycle after.
// A new item is taken only once the block is back in idle (busy low); the
// sweep reads through the single read port of the slot memory. Results
// cannot be stalled.
// Reset: fill count cleared, capacity back to SLOTS, slot memory left as is.
// ----------------------------------------------------------------------
// lru_key_cache_with_prefix_touch
// Fully associative key cache, LRU replacement, prefix touch operation.
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lru_key_cache_with_prefix_touch
  import lkc_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // command channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             opcode,
  input  wire logic [KEY_W-1:0] key_bytes,
  input  wire logic [LEN_W-1:0] key_length,
  // capacity register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [4:0]       active_slots,
  // results
  output logic                  done,
  output logic                  hit,
  output logic [3:0]            slot_used,
  output logic                  evicted,
  output logic [KEY_W-1:0]      evicted_key,
  output logic [LEN_W-1:0]      evicted_length,
  output logic [4:0]            match_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = KEY_W + LEN_W + STAMP_W;

  // Recency is kept as a touch stamp per slot: a larger stamp is more
  // recent, so the rank order of the slots equals the stamp order and the
  // least recent slot is the one with the smallest stamp.

  state_t state, state_next;

  logic [ACT_W-1:0]   act_slots;
  logic [CW-1:0]      filled, filled_next;
  logic [STAMP_W-1:0] stamp, stamp_next;

  // per item
  op_t              op, op_next;
  logic [KEY_W-1:0] key, key_next;
  logic [LEN_W-1:0] len, len_next;
  logic [KEY_W-1:0] pmask, pmask_next;
  logic [CW-1:0]    cnt, cnt_next;     // next slot to read
  logic             pend, pend_next;   // read data valid this cycle
  logic [IW-1:0]    pidx, pidx_next;   // slot of the read data
  logic             found, found_next;
  logic [IW-1:0]    fidx, fidx_next;
  logic             have_lru, have_lru_next;
  logic [IW-1:0]    lru_idx, lru_idx_next;
  logic [STAMP_W-1:0] lru_stamp, lru_stamp_next;
  logic [KEY_W-1:0] lru_key, lru_key_next;
  logic [LEN_W-1:0] lru_len, lru_len_next;
  logic [CW-1:0]    count, count_next;

  // result registers
  logic             done_next, hit_next, evicted_next;
  logic [3:0]       slot_used_next;
  logic [KEY_W-1:0] evicted_key_next;
  logic [LEN_W-1:0] evicted_length_next;
  logic [4:0]       match_count_next;

  // memory ports
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [KEY_W-1:0]   r_key;
  logic [LEN_W-1:0]   r_len;
  logic [STAMP_W-1:0] r_stamp;
  logic [LEN_W-1:0]   len_in;
  logic [ACT_W-1:0]   cap;

  lkc_mem #(.DEPTH(SLOTS), .WIDTH(DW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign {r_key, r_len, r_stamp} = rdata;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // long lengths act as KEY_BYTES
  assign len_in = (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;

  // capacity clamped to 1..SLOTS
  always_comb begin
    if (act_slots == '0) begin
      cap = ACT_W'(1);
    end else if (act_slots > ACT_W'(SLOTS)) begin
      cap = ACT_W'(SLOTS);
    end else begin
      cap = act_slots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      act_slots <= ACT_W'(SLOTS);
      filled    <= '0;
      stamp     <= '0;
      done      <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state  <= state_next;
      filled <= filled_next;
      stamp  <= stamp_next;
      done   <= done_next;
      pend   <= pend_next;
      if (cfg_valid && cfg_ready) begin
        act_slots <= ACT_W'(active_slots);
      end
    end
  end

  always_ff @(posedge clk) begin
    op             <= op_next;
    key            <= key_next;
    len            <= len_next;
    pmask          <= pmask_next;
    cnt            <= cnt_next;
    pidx           <= pidx_next;
    found          <= found_next;
    fidx           <= fidx_next;
    have_lru       <= have_lru_next;
    lru_idx        <= lru_idx_next;
    lru_stamp      <= lru_stamp_next;
    lru_key        <= lru_key_next;
    lru_len        <= lru_len_next;
    count          <= count_next;
    hit            <= hit_next;
    slot_used      <= slot_used_next;
    evicted        <= evicted_next;
    evicted_key    <= evicted_key_next;
    evicted_length <= evicted_length_next;
    match_count    <= match_count_next;
  end

  always_comb begin
    state_next          = state;
    filled_next         = filled;
    stamp_next          = stamp;
    op_next             = op;
    key_next            = key;
    len_next            = len;
    pmask_next          = pmask;
    cnt_next            = cnt;
    pend_next           = 1'b0;
    pidx_next           = pidx;
    found_next          = found;
    fidx_next           = fidx;
    have_lru_next       = have_lru;
    lru_idx_next        = lru_idx;
    lru_stamp_next      = lru_stamp;
    lru_key_next        = lru_key;
    lru_len_next        = lru_len;
    count_next          = count;
    done_next           = 1'b0;
    hit_next            = hit;
    slot_used_next      = slot_used;
    evicted_next        = evicted;
    evicted_key_next    = evicted_key;
    evicted_length_next = evicted_length;
    match_count_next    = match_count;
    we                  = 1'b0;
    waddr               = pidx;
    wdata               = {r_key, r_len, stamp};
    re                  = 1'b0;
    raddr               = cnt[IW-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next       = op_t'(opcode);
          len_next      = len_in;
          pmask_next    = byte_mask(len_in);
          key_next      = key_bytes & byte_mask(len_in);
          cnt_next      = '0;
          found_next    = 1'b0;
          have_lru_next = 1'b0;
          count_next    = '0;
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read a cycle over the filled slots
        if (cnt < filled) begin
          re        = 1'b1;
          cnt_next  = cnt + CW'(1);
          pend_next = 1'b1;
          pidx_next = cnt[IW-1:0];
        end else if (!pend) begin
          state_next = ST_FINISH;
        end
        // check the beat read last cycle
        if (pend) begin
          if (op == OP_INSERT) begin
            if (!found && r_len == len && r_key == key) begin
              found_next = 1'b1;
              fidx_next  = pidx;
            end
            if (!have_lru || r_stamp < lru_stamp) begin
              have_lru_next  = 1'b1;
              lru_idx_next   = pidx;
              lru_stamp_next = r_stamp;
              lru_key_next   = r_key;
              lru_len_next   = r_len;
            end
          end else if (r_len >= len && (r_key & pmask) == key) begin
            // touch in index order: later slots end up more recent
            we         = 1'b1;
            waddr      = pidx;
            wdata      = {r_key, r_len, stamp};
            stamp_next = stamp + STAMP_W'(1);
            count_next = count + CW'(1);
          end
        end
      end

      ST_FINISH: begin
        done_next           = 1'b1;
        hit_next            = 1'b0;
        slot_used_next      = '0;
        evicted_next        = 1'b0;
        evicted_key_next    = '0;
        evicted_length_next = '0;
        match_count_next    = 5'(count);
        if (op == OP_INSERT) begin
          match_count_next = '0;
          we               = 1'b1;
          wdata            = {key, len, stamp};
          stamp_next       = stamp + STAMP_W'(1);
          if (found) begin
            hit_next       = 1'b1;
            waddr          = fidx;
            slot_used_next = 4'(fidx);
          end else if (ACT_W'(filled) < cap) begin
            waddr          = filled[IW-1:0];
            slot_used_next = 4'(filled);
            filled_next    = filled + CW'(1);
          end else begin
            waddr               = lru_idx;
            slot_used_next      = 4'(lru_idx);
            evicted_next        = 1'b1;
            evicted_key_next    = lru_key;
            evicted_length_next = lru_len;
          end
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `LKC_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
  `LKC_ASSERT(a_done_single, done |=> !done, "result strobe held two cycles")
  `LKC_ASSERT(a_evict_no_hit, done && evicted |-> !hit, "eviction reported on a hit")
  `LKC_ASSERT(a_fill_bound, ACT_W'(filled) <= ACT_W'(SLOTS), "fill count past slots")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------
// tb
// Self-checking bench for the LRU key cache: random and directed insert and
// prefix-touch commands, capacity changes between phases, and every result
// checked against an in-bench LRU model.
// ----------------------------------------------------------------------
`default_nettype none
module tb;
  import lkc_pkg::*;

  localparam int NSLOT = 16;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE = 25;  // longer than one item takes in the block

  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct {
    logic             hit;
    logic [3:0]       slot;
    logic             ev;
    logic [KEY_W-1:0] ev_key;
    logic [LEN_W-1:0] ev_len;
    logic [4:0]       mcount;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             opcode = 1'b0;
  logic [KEY_W-1:0] key_bytes = '0;
  logic [LEN_W-1:0] key_length = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [4:0]       active_slots = '0;
  logic             done;
  logic             hit;
  logic [3:0]       slot_used;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [LEN_W-1:0] evicted_length;
  logic [4:0]       match_count;

  lru_key_cache_with_prefix_touch dut (
    .clk, .rst, .start, .busy, .opcode, .key_bytes, .key_length,
    .cfg_valid, .cfg_ready, .active_slots,
    .done, .hit, .slot_used, .evicted, .evicted_key, .evicted_length,
    .match_count
  );

  always #6 clk = ~clk;

  // ---- cache shadow: keys, lengths, ranks (0 = most recent) ----
  logic [KEY_W-1:0] shadow_key [NSLOT];
  logic [LEN_W-1:0] shadow_len [NSLOT];
  int               shadow_rank[NSLOT];
  int               shadow_fill = 0;
  int               shadow_cap_reg = NSLOT;

  cmd_t     cmds_pending[$];
  outcome_t outcomes_due[$];
  int       fail_count = 0;
  bit       idle_free = 0;

  function automatic logic [KEY_W-1:0] lead_mask(int n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < n; b++) m[KEY_W-1-8*b -: 8] = 8'hFF;
    return m;
  endfunction

  // move slot s to most recent; everything newer than it ages by one
  function automatic void make_newest(int s, int old);
    for (int i = 0; i < shadow_fill; i++)
      if (i != s && shadow_rank[i] < old) shadow_rank[i]++;
    shadow_rank[s] = 0;
  endfunction

  function automatic outcome_t cache_apply(cmd_t c);
    outcome_t r;
    int len, s, cap, lru;
    logic [KEY_W-1:0] k;
    bit found;
    r = '{default: '0};
    len = (c.len > KEY_BYTES_DEF) ? KEY_BYTES_DEF : int'(c.len);
    k = c.key & lead_mask(len);
    cap = shadow_cap_reg < 1 ? 1 : (shadow_cap_reg > NSLOT ? NSLOT : shadow_cap_reg);
    found = 0;
    s = 0;
    if (c.op == OP_INSERT) begin
      for (int i = 0; i < shadow_fill; i++)
        if (!found && shadow_len[i] == len && shadow_key[i] == k) begin
          s = i;
          found = 1;
        end
      if (found) begin
        make_newest(s, shadow_rank[s]);
        r.hit = 1'b1;
      end else if (shadow_fill < cap) begin
        s = shadow_fill;
        shadow_fill++;
        shadow_key[s] = k;
        shadow_len[s] = LEN_W'(len);
        make_newest(s, shadow_fill - 1);
      end else begin
        // full (or capacity lowered below fill): replace least recent
        lru = 0;
        for (int i = 0; i < shadow_fill; i++)
          if (shadow_rank[i] > shadow_rank[lru]) lru = i;
        s = lru;
        r.ev = 1'b1;
        r.ev_key = shadow_key[s];
        r.ev_len = shadow_len[s];
        shadow_key[s] = k;
        shadow_len[s] = LEN_W'(len);
        make_newest(s, shadow_rank[s]);
      end
      r.slot = 4'(s);
    end else begin
      // prefix touch: index order, each match promoted in turn
      for (int i = 0; i < shadow_fill; i++)
        if (shadow_len[i] >= len && (shadow_key[i] & lead_mask(len)) == k) begin
          r.mcount++;
          make_newest(i, shadow_rank[i]);
        end
    end
    return r;
  endfunction

  // ---- stimulus helpers ----
  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // bytes from a tiny alphabet so prefixes collide often
  function automatic logic [KEY_W-1:0] clumpy_key();
    logic [KEY_W-1:0] k;
    k = rand64();
    for (int b = 0; b < 8; b++) k[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    return k;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (idle_free || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---- driver: one beat per accepted command ----
  cmd_t cur_cmd;
  int   drv_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) outcomes_due.push_back(cache_apply(cur_cmd));
      if (!start || !busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          start <= 1'b0;
        end else if (cmds_pending.size() > 0) begin
          cur_cmd = cmds_pending.pop_front();
          opcode <= cur_cmd.op;
          key_bytes <= cur_cmd.key;
          key_length <= cur_cmd.len;
          start <= 1'b1;
          drv_gap = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: done strobe is a single-cycle beat ----
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        e = outcomes_due.pop_front();
        if (hit !== e.hit) begin
          $error("hit exp %h got %h", e.hit, hit); fail_count++;
        end
        if (slot_used !== e.slot) begin
          $error("slot_used exp %h got %h", e.slot, slot_used); fail_count++;
        end
        if (evicted !== e.ev) begin
          $error("evicted exp %h got %h", e.ev, evicted); fail_count++;
        end
        if (evicted_key !== e.ev_key) begin
          $error("evicted_key exp %h got %h", e.ev_key, evicted_key); fail_count++;
        end
        if (evicted_length !== e.ev_len) begin
          $error("evicted_length exp %h got %h", e.ev_len, evicted_length); fail_count++;
        end
        if (match_count !== e.mcount) begin
          $error("match_count exp %h got %h", e.mcount, match_count); fail_count++;
        end
      end
    end
  end

  // ---- sequencing ----
  task automatic queue_cmd(op_t op, logic [KEY_W-1:0] k, logic [LEN_W-1:0] n);
    cmd_t c;
    c.op = op;
    c.key = k;
    c.len = n;
    cmds_pending.push_back(c);
  endtask

  task automatic drain();
    while (cmds_pending.size() > 0 || start || outcomes_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    cfg_valid <= 1'b1;
    active_slots <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_cap_reg = int'(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase();
    logic [KEY_W-1:0] pool_key[6];
    int               pool_len[6];
    int j, n;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < 6; i++) begin
      pool_key[i] = clumpy_key();
      pool_len[i] = $urandom_range(0, 8);
    end
    for (int t = 0; t < PHASE_ITEMS; t++) begin
      j = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // reinsert a known key; bytes past its length are junk
          k = (pool_key[j] & lead_mask(pool_len[j])) | (rand64() & ~lead_mask(pool_len[j]));
          queue_cmd(OP_INSERT, k, LEN_W'(pool_len[j]));
        end
        4, 5, 6: begin
          k = ($urandom_range(0, 3) == 0) ? rand64() : clumpy_key();
          n = $urandom_range(0, 15);
          queue_cmd(OP_INSERT, k, LEN_W'(n));
          pool_key[j] = k;
          pool_len[j] = n > 8 ? 8 : n;
        end
        7, 8: begin
          // prefix of a known key, length up to one past it
          n = $urandom_range(0, pool_len[j] + 1);
          k = (pool_key[j] & lead_mask(n > 8 ? 8 : n)) | (rand64() & ~lead_mask(n > 8 ? 8 : n));
          queue_cmd(OP_PREFIX, k, LEN_W'(n));
        end
        default: queue_cmd(OP_PREFIX, rand64(), LEN_W'($urandom_range(0, 15)));
      endcase
    end
  endtask

  initial begin
    logic [4:0] caps[8];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd2, 5'd16};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: key extremes, masking, long lengths, empty and long prefixes
    queue_cmd(OP_INSERT, '0, 4'd0);
    queue_cmd(OP_INSERT, '1, 4'd0);                 // same empty key: hit
    queue_cmd(OP_INSERT, '1, 4'd8);
    queue_cmd(OP_INSERT, '1, 4'd15);                // clamps to 8: hit
    queue_cmd(OP_INSERT, 64'h4142_4344_0000_0000, 4'd4);
    queue_cmd(OP_INSERT, 64'h4142_4344_FFFF_FFFF, 4'd4);  // junk tail: hit
    queue_cmd(OP_INSERT, 64'h4142_4300_0000_0000, 4'd3);
    queue_cmd(OP_INSERT, 64'h4142_0000_0000_0000, 4'd2);
    queue_cmd(OP_INSERT, 64'h0000_0000_0000_0000, 4'd8);
    queue_cmd(OP_PREFIX, 64'h4142_FFFF_FFFF_FFFF, 4'd2);
    queue_cmd(OP_PREFIX, '1, 4'd0);                 // matches all
    queue_cmd(OP_PREFIX, '1, 4'd15);
    queue_cmd(OP_PREFIX, 64'h4142_4344_0000_0000, 4'd5);  // longer than stored
    queue_cmd(OP_PREFIX, 64'h5A00_0000_0000_0000, 4'd1);  // no match
    queue_cmd(OP_INSERT, 64'h4142_0000_0000_0000, 4'd2);
    queue_cmd(OP_INSERT, 64'h8000_0000_0000_0001, 4'd8);
    queue_cmd(OP_PREFIX, 64'h0, 4'd9);
    drain();

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      idle_free = (p % 3 == 2);
      random_phase();
      drain();
    end

    if (fail_count == 0) begin
      $display("lru_key_cache_with_prefix_touch verification clean");
    end else begin
      $display("lru_key_cache_with_prefix_touch verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("lru_key_cache_with_prefix_touch verification failed");
    $finish;
  end

endmodule
`default_nettype wire
